// ===== rtl/core/gradient_nonmax_suppression_unit_assert.svh =====
// assertion macros for the checker file
`ifndef GRADIENT_NONMAX_SUPPRESSION_UNIT_ASSERT_SVH
`define GRADIENT_NONMAX_SUPPRESSION_UNIT_ASSERT_SVH

// same-cycle implication, reset masks the check
`define GNMS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define GNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gnms_pkg.sv =====
// shared widths, register codes and ring index helpers
`default_nettype none
package gnms_pkg;
    localparam int GNMS_MAX_WIDTH = 1024;
    localparam int PIX_W          = 8;
    localparam int MAG_W          = 9;
    localparam int GRAD_W         = 9;
    localparam int FW_W           = 11;
    localparam int FH_W           = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int OUT_DATA_W     = 16;
    localparam int MAG_LIMIT      = 361;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef logic [1:0] t_ring;

    function automatic t_ring ring_inc(input t_ring x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    function automatic t_ring ring_dec(input t_ring x);
        return (x == 2'd0) ? 2'd2 : x - 2'd1;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/gradient_nonmax_suppression_unit.sv =====
// gradient, magnitude and non-maximum suppression over three-row line memories
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/tready         tdata pixel, tuser cmd (1 = flush)
// m_axis    out  m_axis_tvalid/tready         tdata magnitude, tuser mark, tlast
// cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// an item is taken in, then its gradient is written back; an interior gradient
// needs three pixel reads, two squares and the 9-step square root, and an
// interior suppression reads the centre and four neighbours through one read
// port, then makes four products and two compares; a zero centre magnitude ends it early
// a flush before the last pixel of the frame is accepted and dropped
// synchronous active-low reset clears counters and control, not the line memories
// a stalled result sits in the output register while the next item is worked on
`default_nettype none
module gradient_nonmax_suppression_unit #(
    parameter int MAX_WIDTH = gnms_pkg::GNMS_MAX_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [gnms_pkg::PIX_W-1:0]        s_axis_tdata,  // [7:0] pixel
    input  wire logic                              s_axis_tuser,  // [0] cmd
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [gnms_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [8:0] magnitude
    output logic                                   m_axis_tuser,  // [0] edge_candidate
    output logic                                   m_axis_tlast,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gnms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gnms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gnms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);        // column index bits
    localparam int WW = $clog2(MAX_WIDTH + 1);    // used width bits
    localparam int AW = CW + 2;                   // ring row + column
    localparam int DEPTH = 3 << CW;

    typedef enum logic [3:0] {
        S_IDLE, S_PIX0, S_PIX1, S_PIX2, S_PIX3, S_SQA, S_SQB, S_SQW,
        S_GWR, S_SUP0, S_SUP1, S_NRD, S_NRL, S_CMP, S_OUT
    } t_state;

    t_state                  r_state;
    logic [FW_W-1:0]         r_fw;
    logic [FH_W-1:0]         r_fh;
    logic [CW-1:0]           r_col;
    logic [FH_W-1:0]         r_row;
    t_ring                   r_rm;          // row modulo three
    logic [PIX_W-1:0]        r_pix;
    logic [PIX_W-1:0]        r_pw;
    logic [PIX_W-1:0]        r_pe;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic [16:0]             r_acc;
    logic                    r_sq_start;
    logic [MAG_W-1:0]        r_mag;
    logic [MAG_W-1:0]        r_g [4];       // g1..g4
    logic [1:0]              r_k;
    logic signed [20:0]      r_prod;
    logic                    r_ok;
    logic                    r_mark;
    logic                    r_has;
    logic                    r_lastf;
    logic                    r_out_valid;
    logic [MAG_W-1:0]        r_out_mag;
    logic                    r_out_mark;
    logic                    r_out_last;

    // used frame size, clamped
    logic [31:0]    fw32;
    logic [31:0]    fh32;
    logic [WW-1:0]  w;
    logic [FH_W-1:0] h;

    assign fw32 = 32'(r_fw);
    assign fh32 = 32'(r_fh);
    assign w = WW'((fw32 < 32'd5) ? 32'd5 :
                   ((fw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : fw32));
    assign h = FH_W'((fh32 < 32'd3) ? 32'd3 : ((fh32 > 32'd4096) ? 32'd4096 : fh32));

    // position decode
    t_ring          aidx;
    logic [CW-1:0]  col_m1;
    logic [CW-1:0]  col_p1;
    logic           col_last;
    logic           row_in;
    logic           grad_int;
    logic           grad_wr;

    assign aidx     = ring_dec(r_rm);
    assign col_m1   = r_col - CW'(1);
    assign col_p1   = r_col + CW'(1);
    assign col_last = (WW'(r_col) == w - WW'(1));
    assign row_in   = (r_row < h);
    assign grad_int = (r_row >= FH_W'(2)) && row_in && (r_col != '0) && !col_last;
    assign grad_wr  = (r_row >= FH_W'(1)) && (r_row <= h);

    // suppression position: one column back, or end of the row before
    logic           sup_valid;
    logic [FH_W-1:0] sup_r;
    logic [CW-1:0]  sup_c;
    t_ring          sup_r0;
    t_ring          sup_rn;
    t_ring          sup_rs;
    logic           sup_int;
    logic           sup_last;
    logic [CW-1:0]  sup_cm;
    logic [CW-1:0]  sup_cp;

    always_comb begin
        if (r_col != '0) begin
            sup_valid = (r_row >= FH_W'(2)) && ((r_row - FH_W'(2)) < h);
            sup_r     = r_row - FH_W'(2);
            sup_c     = col_m1;
            sup_r0    = ring_dec(aidx);
        end else begin
            sup_valid = (r_row >= FH_W'(3)) && ((r_row - FH_W'(3)) < h);
            sup_r     = r_row - FH_W'(3);
            sup_c     = CW'(w - WW'(1));
            sup_r0    = r_rm;
        end
    end

    assign sup_rn   = ring_dec(sup_r0);
    assign sup_rs   = ring_inc(sup_r0);
    assign sup_cm   = sup_c - CW'(1);
    assign sup_cp   = sup_c + CW'(1);
    assign sup_last = (sup_r == h - FH_W'(1)) && (WW'(sup_c) == w - WW'(1));
    assign sup_int  = (sup_r != '0) && (sup_r != h - FH_W'(1)) && (sup_c != '0) &&
                      (WW'(sup_c) != w - WW'(1));

    // direction of the centre gradient
    logic [PIX_W-1:0] ax;
    logic [PIX_W-1:0] ay;
    logic             same;
    logic             steep;
    logic [PIX_W-1:0] wmax;
    logic [PIX_W-1:0] wmin;

    assign ax    = r_gx[GRAD_W-1] ? PIX_W'(-r_gx) : PIX_W'(r_gx);
    assign ay    = r_gy[GRAD_W-1] ? PIX_W'(-r_gy) : PIX_W'(r_gy);
    assign same  = ((r_gx > 0) && (r_gy > 0)) || ((r_gx < 0) && (r_gy < 0));
    assign steep = (ay > ax);
    assign wmax  = steep ? ay : ax;
    assign wmin  = steep ? ax : ay;

    // neighbour address for g1..g4
    logic [AW-1:0] nbr_addr;

    always_comb begin
        unique case (r_k)
            2'd0: begin
                if (steep) begin
                    nbr_addr = same ? {sup_rn, sup_cm} : {sup_rn, sup_cp};
                end else begin
                    nbr_addr = same ? {sup_rs, sup_cp} : {sup_rn, sup_cp};
                end
            end
            2'd1: nbr_addr = steep ? {sup_rn, sup_c} : {sup_r0, sup_cp};
            2'd2: begin
                if (steep) begin
                    nbr_addr = same ? {sup_rs, sup_cp} : {sup_rs, sup_cm};
                end else begin
                    nbr_addr = same ? {sup_rn, sup_cm} : {sup_rs, sup_cm};
                end
            end
            default: nbr_addr = steep ? {sup_rs, sup_c} : {sup_r0, sup_cm};
        endcase
    end

    // line memories
    logic                 pix_we;
    logic [AW-1:0]        pix_raddr;
    logic [PIX_W-1:0]     pix_rdata;
    logic                 mag_we;
    logic [AW-1:0]        mag_raddr;
    logic [MAG_W-1:0]     mag_rdata;
    logic [2*GRAD_W-1:0]  grd_rdata;

    assign pix_we = (r_state == S_PIX0) && row_in;
    assign mag_we = (r_state == S_GWR);

    always_comb begin
        unique case (r_state)
            S_PIX0:  pix_raddr = {aidx, col_m1};
            S_PIX1:  pix_raddr = {aidx, col_p1};
            default: pix_raddr = {ring_dec(aidx), r_col};
        endcase
    end

    assign mag_raddr = (r_state == S_SUP0) ? {sup_r0, sup_c} : nbr_addr;

    gnms_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr ({r_rm, r_col}),
        .i_wdata (r_pix),
        .i_raddr (pix_raddr),
        .o_rdata (pix_rdata)
    );

    gnms_ram #(.WIDTH(MAG_W), .DEPTH(DEPTH)) u_mag_ram (
        .i_clk   (i_clk),
        .i_we    (mag_we),
        .i_waddr ({aidx, r_col}),
        .i_wdata (r_mag),
        .i_raddr (mag_raddr),
        .o_rdata (mag_rdata)
    );

    gnms_ram #(.WIDTH(2 * GRAD_W), .DEPTH(DEPTH)) u_grd_ram (
        .i_clk   (i_clk),
        .i_we    (mag_we),
        .i_waddr ({aidx, r_col}),
        .i_wdata ({r_gy, r_gx}),
        .i_raddr ({sup_r0, sup_c}),
        .o_rdata (grd_rdata)
    );

    // shared multiplier: squares, then the four interpolation products
    logic signed [9:0]  mul_a;
    logic signed [10:0] mul_b;
    logic signed [20:0] prod;

    always_comb begin
        mul_a = 10'(r_gx);
        mul_b = 11'(r_gx);
        if (r_state == S_SQB) begin
            mul_a = 10'(r_gy);
            mul_b = 11'(r_gy);
        end else if (r_state == S_CMP) begin
            mul_a = r_k[0] ? $signed({2'b00, wmin}) : $signed({2'b00, wmax});
            unique case (r_k)
                2'd0: mul_b = $signed({2'b00, r_mag}) - $signed({2'b00, r_g[1]});
                2'd1: mul_b = $signed({2'b00, r_g[0]}) - $signed({2'b00, r_g[1]});
                2'd2: mul_b = $signed({2'b00, r_mag}) - $signed({2'b00, r_g[3]});
                default: mul_b = $signed({2'b00, r_g[2]}) - $signed({2'b00, r_g[3]});
            endcase
        end
    end

    assign prod = 21'(mul_a * mul_b);

    // square root unit
    logic             sq_done;
    logic [MAG_W-1:0] sq_root;

    gnms_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_radicand (r_acc),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fw        <= FW_W'(640);
            r_fh        <= FH_W'(480);
            r_col       <= '0;
            r_row       <= '0;
            r_rm        <= '0;
            r_sq_start  <= 1'b0;
            r_k         <= '0;
            r_has       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sq_start <= 1'b0;
            // a transfer frees the register unless a new result loads it now
            if (r_out_valid && m_axis_tready && !((r_state == S_OUT) && r_has)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        unique case (t_cfg_index'(i_cfg_index))
                            CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[FW_W-1:0];
                            CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                        endcase
                        r_col <= '0;
                        r_row <= '0;
                        r_rm  <= '0;
                    end else if (s_axis_tvalid) begin
                        // flush inside the frame is dropped
                        if (!(row_in && s_axis_tuser)) begin
                            r_pix   <= s_axis_tdata;
                            r_state <= S_PIX0;
                        end
                    end
                end
                S_PIX0: begin
                    if (grad_int) begin
                        r_state <= S_PIX1;
                    end else begin
                        r_gx  <= '0;
                        r_gy  <= '0;
                        r_mag <= '0;
                        r_state <= grad_wr ? S_GWR : S_SUP0;
                    end
                end
                S_PIX1: begin
                    r_pw    <= pix_rdata;
                    r_state <= S_PIX2;
                end
                S_PIX2: begin
                    r_pe    <= pix_rdata;
                    r_state <= S_PIX3;
                end
                S_PIX3: begin
                    r_gx    <= $signed({1'b0, r_pe}) - $signed({1'b0, r_pw});
                    r_gy    <= $signed({1'b0, r_pix}) - $signed({1'b0, pix_rdata});
                    r_state <= S_SQA;
                end
                S_SQA: begin
                    r_acc   <= 17'(prod);
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_acc      <= r_acc + 17'(prod);
                    r_sq_start <= 1'b1;
                    r_state    <= S_SQW;
                end
                S_SQW: begin
                    if (sq_done) begin
                        r_mag   <= sq_root;
                        r_state <= S_GWR;
                    end
                end
                S_GWR: begin
                    r_state <= S_SUP0;
                end
                S_SUP0: begin
                    r_lastf <= sup_last;
                    r_mark  <= 1'b0;
                    r_mag   <= '0;
                    if (!sup_valid) begin
                        r_has   <= 1'b0;
                        r_state <= S_OUT;
                    end else if (!sup_int) begin
                        r_has   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SUP1;
                    end
                end
                S_SUP1: begin
                    r_gx  <= grd_rdata[GRAD_W-1:0];
                    r_gy  <= grd_rdata[2*GRAD_W-1:GRAD_W];
                    r_mag <= mag_rdata;
                    r_k   <= '0;
                    if (mag_rdata == '0) begin
                        r_has   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_NRD;
                    end
                end
                S_NRD: begin
                    if (r_k != 2'd0) begin
                        r_g[r_k - 2'd1] <= mag_rdata;
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_NRL;
                    end
                end
                S_NRL: begin
                    r_g[3]  <= mag_rdata;
                    r_k     <= '0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_k <= r_k + 2'd1;
                    unique case (r_k)
                        2'd0: r_prod <= prod;
                        2'd1: r_ok   <= (r_prod >= prod);
                        2'd2: r_prod <= prod;
                        default: begin
                            r_mark  <= r_ok && (r_prod >= prod);
                            r_has   <= 1'b1;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (!r_has || out_free) begin
                        if (r_has) begin
                            r_out_valid <= 1'b1;
                            r_out_mag   <= r_mag;
                            r_out_mark  <= r_mark;
                            r_out_last  <= r_lastf;
                        end
                        // advance the raster position
                        if ((r_row == h + FH_W'(2)) && (r_col == '0)) begin
                            r_col <= '0;
                            r_row <= '0;
                            r_rm  <= '0;
                        end else if (col_last) begin
                            r_col <= '0;
                            r_row <= r_row + FH_W'(1);
                            r_rm  <= ring_inc(r_rm);
                        end else begin
                            r_col <= col_p1;
                        end
                        r_has   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_mag);
    assign m_axis_tuser  = r_out_mark;
    assign m_axis_tlast  = r_out_last;
endmodule
`default_nettype wire

// ===== rtl/core/gnms_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module gnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/gnms_sqrt.sv =====
// iterative rounded square root, two radicand bits a cycle
`default_nettype none
module gnms_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [16:0]                 i_radicand,
    output logic                             o_done,
    output logic      [gnms_pkg::MAG_W-1:0]  o_root
);
    import gnms_pkg::*;

    logic [17:0]      r_rad;
    logic [11:0]      r_rem;
    logic [MAG_W-1:0] r_root;
    logic [3:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [11:0]      cur;
    logic [11:0]      trial;
    logic             ge;

    assign cur   = {r_rem[9:0], r_rad[17:16]};
    assign trial = {1'b0, r_root, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= {1'b0, i_radicand};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 4'd9;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[15:0], 2'b00};
                r_rem  <= ge ? (cur - trial) : cur;
                r_root <= {r_root[MAG_W-2:0], ge};
                r_cnt  <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // round up when the remainder exceeds the root
    assign o_done = r_done;
    assign o_root = r_root + MAG_W'(r_rem > 12'(r_root));
endmodule
`default_nettype wire

// ===== rtl/core/gnms_checker.sv =====
// port-level checks for the suppression unit, bound to the top level
`default_nettype none
`include "gradient_nonmax_suppression_unit_assert.svh"
module gnms_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [gnms_pkg::PIX_W-1:0]        s_axis_tdata,
    input wire logic                              s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [gnms_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input wire logic                              m_axis_tuser,
    input wire logic                              m_axis_tlast,
    input wire logic                              i_cfg_valid,
    input wire logic                              o_cfg_ready,
    input wire logic [gnms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input wire logic [gnms_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gnms_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata, m_axis_tlast, i_cfg_index, i_cfg_data};

    // a held result keeps its payload
    `GNMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    // a pixel transfer starts work, so the input closes
    `GNMS_ASSERT_NEXT(a_pix_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready && !o_cfg_ready, "input open right after a pixel")
    // input only opens when configuration may also be taken
    `GNMS_ASSERT_SAME(a_ready_pair, i_clk, i_rst_n, s_axis_tready, o_cfg_ready && !i_cfg_valid, "input ready outside idle")
    // magnitude in range, a mark needs a nonzero magnitude
    `GNMS_ASSERT_SAME(a_mag_range, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata <= OUT_DATA_W'(MAG_LIMIT)) && (!m_axis_tuser || (m_axis_tdata != '0)) && (unused_ok || !unused_ok), "bad magnitude or mark")
endmodule

bind gradient_nonmax_suppression_unit gnms_checker u_gnms_checker (.*);
`default_nettype wire
